FILE: rtl/h264_sps_syntax_parser_unit_macros.svh
// Assertion macros for the SPS parser unit checker.
// Used only by the checker file; it has no other dependencies.
`ifndef H264_SPS_SYNTAX_PARSER_UNIT_MACROS_SVH
`define H264_SPS_SYNTAX_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define SPS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sps parser check failed");

// Next-cycle implication, disabled in reset
`define SPS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sps parser check failed");

`endif

FILE: rtl/h264sps_pkg.sv
// Shared types, constants and the syntax kind table of the SPS parser.
// No dependencies.
package h264sps_pkg;

  localparam int MAX_CODE_BITS_DEF = 32;
  localparam int QUEUE_DEPTH       = 4;

  localparam logic [6:0] K_UE = 7'd64;
  localparam logic [6:0] K_SE = 7'd65;

  // Syntax positions with a special role
  localparam logic [6:0] POS_LIST_FLAG = 7'd14;
  localparam logic [6:0] POS_SCALE     = 7'd15;
  localparam logic [6:0] ID_HELD_SCALE = 7'd16;
  localparam logic [6:0] POS_DONE      = 7'd90;
  localparam logic [6:0] POS_ERROR     = 7'd91;
  localparam int         NUM_POS       = 90;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_LONG  = 2'd1,
    ST_EARLY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_BITS,
    PH_FIN
  } phase_e;

  // Queue entry between front and back
  typedef struct packed {
    logic       drop;
    logic       fin;
    logic [7:0] data;
  } q_entry_t;

  // One decoded element
  typedef struct packed {
    status_e     status;
    logic [32:0] value;
    logic [9:0]  index;
    logic [6:0]  id;
  } result_t;

  // Bit count for fixed fields, K_UE / K_SE for Exp-Golomb, 0 unused
  localparam logic [6:0] KIND_TABLE [0:NUM_POS-1] = '{
    7'd8, 7'd1, 7'd1, 7'd1, 7'd1, 7'd4, 7'd8, K_UE, K_UE, 7'd1,
    K_UE, K_UE, 7'd1, 7'd1, 7'd1, K_SE, 7'd0, K_UE, K_UE, K_UE,
    7'd1, K_SE, K_SE, K_UE, K_SE, K_UE, 7'd1, K_UE, K_UE, 7'd1,
    7'd1, 7'd1, 7'd1, K_UE, K_UE, K_UE, K_UE, 7'd1, 7'd1, 7'd8,
    7'd16, 7'd16, 7'd1, 7'd1, 7'd1, 7'd3, 7'd1, 7'd1, 7'd8, 7'd8,
    7'd8, 7'd1, K_UE, K_UE, 7'd1, 7'd32, 7'd32, 7'd1, 7'd1, K_UE,
    7'd4, 7'd4, K_UE, K_UE, 7'd1, 7'd5, 7'd5, 7'd5, 7'd5, 7'd1,
    K_UE, 7'd4, 7'd4, K_UE, K_UE, 7'd1, 7'd5, 7'd5, 7'd5, 7'd5,
    7'd1, 7'd1, 7'd1, 7'd1, K_UE, K_UE, K_UE, K_UE, K_UE, K_UE
  };

  function automatic logic [6:0] kind_of(input logic [6:0] pos);
    logic [6:0] k;
    k = 7'd0;
    if (pos < POS_DONE) k = KIND_TABLE[pos];
    return k;
  endfunction

endpackage

FILE: rtl/h264_sps_syntax_parser_unit.sv
// H.264 SPS syntax parser: bytes in, decoded syntax elements out.
//
// Slave stream: one SPS payload byte per transaction (after the NAL
// header, escapes included); tlast marks the last byte of the set.
// Master stream: one decoded element per transaction; tlast marks the
// end-of-set marker element (id 90) that closes every set.
// A byte accepted on the slave port is written into the queue, then loaded
// into the decoder's byte register, and its bits are decoded from there.
// Bits are decoded one per cycle while the receiver does not stall; after
// the last byte the end-of-set marker takes a step of its own. An element is
// presented on the cycle after the cycle that decodes its last bit.
// While the queue holds a byte the decoder moves straight on to it after
// the last bit of the current one; otherwise it idles until a byte arrives.
// A 4-entry byte queue lets the sender run ahead of the decoder.
// Reset returns to the start of a set; the end-of-set marker does too.
// When the receiver stalls, the result register holds and the decoder
// waits; the byte queue keeps accepting until it is full.
module h264_sps_syntax_parser_unit #(
  parameter int MAX_CODE_BITS = h264sps_pkg::MAX_CODE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] payload_byte
  input  logic        s_axis_tlast,   // final_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [6:0] element_id, [16:7] element_index,
                                      // [49:17] element_value, [51:50] parse_status
  output logic        m_axis_tlast    // end_of_set
);

  logic                  q_full, q_push, q_pop, q_valid;
  h264sps_pkg::q_entry_t q_in, q_out;
  h264sps_pkg::result_t  res;

  h264sps_front u_front (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .q_full_i(q_full), .q_push_o(q_push), .q_entry_o(q_in)
  );

  h264sps_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(q_push), .entry_i(q_in), .full_o(q_full),
    .pop_i(q_pop), .valid_o(q_valid), .entry_o(q_out)
  );

  h264sps_back #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_entry_i(q_out), .q_pop_o(q_pop),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_res_o(res)
  );

  // Pack result fields, id in the lowest bits and zero padding on top
  assign m_axis_tdata = {4'd0, res.status, res.value, res.index, res.id};
  assign m_axis_tlast = (res.id == h264sps_pkg::POS_DONE);

endmodule

FILE: rtl/h264sps_front.sv
// Front end: accepts payload bytes and marks emulation-prevention bytes.
// Depends on h264sps_pkg.
module h264sps_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] payload_byte
  input  logic                 s_axis_tlast,   // final_byte
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output h264sps_pkg::q_entry_t q_entry_o
);

  logic [1:0] zero_run_q, zero_run_d;
  logic       drop;

  assign s_axis_tready = !q_full_i;
  assign q_push_o      = s_axis_tvalid && !q_full_i;

  // 0x03 after two zero bytes is dropped
  assign drop = (zero_run_q == 2'd2) && (s_axis_tdata == 8'h03);

  always_comb begin
    zero_run_d = zero_run_q;
    if (drop) begin
      zero_run_d = 2'd0;
    end else if (s_axis_tdata == 8'h00) begin
      if (zero_run_q != 2'd2) zero_run_d = zero_run_q + 2'd1;
    end else begin
      zero_run_d = 2'd0;
    end
  end

  assign q_entry_o = '{drop: drop, fin: s_axis_tlast, data: s_axis_tdata};

  // Run resets with the set so a new set starts clean
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_run_q <= 2'd0;
    end else if (q_push_o) begin
      zero_run_q <= s_axis_tlast ? 2'd0 : zero_run_d;
    end
  end

endmodule

FILE: rtl/h264sps_queue.sv
// Short queue of classified bytes between front and back end.
// Depends on h264sps_pkg.
module h264sps_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  h264sps_pkg::q_entry_t entry_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output h264sps_pkg::q_entry_t entry_o
);

  localparam int Depth = h264sps_pkg::QUEUE_DEPTH;
  localparam int PtrW  = $clog2(Depth);

  h264sps_pkg::q_entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

  // Pointers wrap naturally for a power-of-two depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

endmodule

FILE: rtl/h264sps_back.sv
// Back end: bit-serial Exp-Golomb / fixed-field decoder and SPS sequencer.
// Depends on h264sps_pkg; holds the output register of the stream port.
module h264sps_back #(
  parameter int MAX_CODE_BITS = h264sps_pkg::MAX_CODE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  h264sps_pkg::q_entry_t q_entry_i,
  output logic                  q_pop_o,
  output logic                  m_valid_o,
  input  logic                  m_ready_i,
  output h264sps_pkg::result_t  m_res_o
);

  // Control
  h264sps_pkg::phase_e phase_q, phase_d;
  logic [2:0] bit_q;
  logic [7:0] byte_q;
  logic       fin_q, drop_q;
  logic       step, last_bit;

  // Decoder state
  logic [6:0]  pos_q, pos_d;
  logic [5:0]  lz_q, lz_d;
  logic [31:0] acc_q, acc_d;
  logic [5:0]  left_q, left_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [7:0]  lim_q, lim_d;
  logic [3:0]  sln_q, sln_d;
  logic [7:0]  prev_q, prev_d;
  logic        high_q, high_d, f444_q, f444_d, nal_q, nal_d, vcl_q, vcl_d;
  logic        sfx_q, sfx_d;

  // Output register
  logic                 oval_q;
  h264sps_pkg::result_t ores_q;
  logic                 emit;
  h264sps_pkg::result_t eres;

  // Datapath temporaries
  logic        b, fixed, done, flag_v;
  logic [6:0]  kind, nxt, ld_nxt, nkind;
  logic [31:0] acc_n;
  logic [32:0] code, mag, v;
  logic [9:0]  idx;
  logic [7:0]  ns;
  logic [8:0]  cnt_inc;
  logic [4:0]  sln_inc;

  assign last_bit = (bit_q == 3'd7);
  assign step     = (phase_q != h264sps_pkg::PH_IDLE) && (!oval_q || m_ready_i);

  // Phase sequencing
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      h264sps_pkg::PH_IDLE: if (q_valid_i) phase_d = h264sps_pkg::PH_BITS;
      h264sps_pkg::PH_BITS: begin
        if (step && last_bit) begin
          if (fin_q)          phase_d = h264sps_pkg::PH_FIN;
          else if (q_valid_i) phase_d = h264sps_pkg::PH_BITS;
          else                phase_d = h264sps_pkg::PH_IDLE;
        end
      end
      h264sps_pkg::PH_FIN: begin
        if (step) phase_d = q_valid_i ? h264sps_pkg::PH_BITS : h264sps_pkg::PH_IDLE;
      end
      default: phase_d = h264sps_pkg::PH_IDLE;
    endcase
  end

  // Queue pop: load a new byte when the current one is finished
  always_comb begin
    unique case (phase_q)
      h264sps_pkg::PH_IDLE: q_pop_o = q_valid_i;
      h264sps_pkg::PH_BITS: q_pop_o = q_valid_i && step && last_bit && !fin_q;
      h264sps_pkg::PH_FIN:  q_pop_o = q_valid_i && step;
      default:              q_pop_o = 1'b0;
    endcase
  end

  // Array index of the current element
  always_comb begin
    unique case (pos_q)
      h264sps_pkg::POS_LIST_FLAG: idx = {6'd0, sln_q};
      h264sps_pkg::POS_SCALE:     idx = {sln_q, cnt_q[5:0]};
      7'd24, 7'd62, 7'd63, 7'd64, 7'd73, 7'd74, 7'd75: idx = {2'd0, cnt_q};
      default:                    idx = 10'd0;
    endcase
  end

  // One bit of decoding, or the end-of-set marker in the final phase
  always_comb begin
    b       = byte_q[3'd7 - bit_q];
    kind    = h264sps_pkg::kind_of(pos_q);
    fixed   = (kind != 7'd0) && (kind <= 7'd32);
    acc_n   = {acc_q[30:0], b};
    done    = 1'b0;
    code    = 33'd0;
    nxt     = pos_q;
    emit    = 1'b0;
    eres    = '{status: h264sps_pkg::ST_OK, value: 33'd0, index: idx, id: pos_q};
    pos_d   = pos_q;  lz_d  = lz_q;  acc_d = acc_q;  left_d = left_q;
    cnt_d   = cnt_q;  lim_d = lim_q; sln_d = sln_q;  prev_d = prev_q;
    high_d  = high_q; f444_d = f444_q; nal_d = nal_q; vcl_d = vcl_q;
    sfx_d   = sfx_q;
    mag     = 33'd0;
    v       = 33'd0;
    ns      = 8'd0;
    flag_v  = 1'b0;
    cnt_inc = {1'b0, cnt_q} + 9'd1;
    sln_inc = {1'b0, sln_q} + 5'd1;
    ld_nxt  = (sln_inc < (f444_q ? 5'd12 : 5'd8)) ? h264sps_pkg::POS_LIST_FLAG : 7'd17;
    nkind   = 7'd0;

    if (phase_q == h264sps_pkg::PH_FIN) begin
      // End of set marker, then back to reset state
      emit = 1'b1;
      eres.id    = h264sps_pkg::POS_DONE;
      eres.index = 10'd0;
      eres.status = (pos_q == h264sps_pkg::POS_DONE)  ? h264sps_pkg::ST_OK :
                    (pos_q == h264sps_pkg::POS_ERROR) ? h264sps_pkg::ST_LONG :
                                                        h264sps_pkg::ST_EARLY;
      pos_d = 7'd0; lz_d = 6'd0; acc_d = 32'd0; left_d = 6'd8;
      cnt_d = 8'd0; lim_d = 8'd0; sln_d = 4'd0; prev_d = 8'd8;
      high_d = 1'b0; f444_d = 1'b0; nal_d = 1'b0; vcl_d = 1'b0; sfx_d = 1'b0;
    end else if (!drop_q && pos_q < h264sps_pkg::POS_DONE) begin
      if (fixed) begin
        acc_d  = acc_n;
        left_d = left_q - 6'd1;
        if (left_q == 6'd1) begin
          done = 1'b1;
          code = {1'b0, acc_n};
        end
      end else if (!sfx_q) begin
        // Prefix: count leading zeros
        if (!b) begin
          lz_d = lz_q + 6'd1;
          if ((7'(lz_q) + 7'd1) >= 7'(MAX_CODE_BITS)) begin
            emit = 1'b1;
            eres.status = h264sps_pkg::ST_LONG;
            pos_d = h264sps_pkg::POS_ERROR;
          end
        end else if (lz_q == 6'd0) begin
          done = 1'b1;
        end else begin
          sfx_d  = 1'b1;
          left_d = lz_q;
          acc_d  = 32'd0;
        end
      end else begin
        acc_d  = acc_n;
        left_d = left_q - 6'd1;
        if (left_q == 6'd1) begin
          done = 1'b1;
          code = ((33'd1 << lz_q) - 33'd1) + {1'b0, acc_n};
        end
      end

      if (done) begin
        mag = (code + 33'd1) >> 1;
        v   = (kind == h264sps_pkg::K_SE) ? (code[0] ? mag : (33'd0 - mag)) : code;
        flag_v = (v != 33'd0);
        emit = 1'b1;
        if (pos_q == h264sps_pkg::POS_SCALE) begin
          ns = prev_q + v[7:0];
          if (ns == 8'd0) begin
            eres.id    = h264sps_pkg::ID_HELD_SCALE;
            eres.value = {25'd0, prev_q};
            sln_d = sln_inc[3:0];
            nxt   = ld_nxt;
          end else begin
            prev_d = ns;
            eres.value = {25'd0, ns};
            cnt_d = cnt_inc[7:0];
            if (cnt_inc < ((sln_q < 4'd6) ? 9'd16 : 9'd64)) begin
              nxt = h264sps_pkg::POS_SCALE;
            end else begin
              sln_d = sln_inc[3:0];
              nxt   = ld_nxt;
            end
          end
        end else begin
          eres.value = v;
          nxt = pos_q + 7'd1;
          unique case (pos_q)
            7'd0: begin
              if (v == 33'd100 || v == 33'd110 || v == 33'd122 || v == 33'd244 ||
                  v == 33'd44 || v == 33'd83 || v == 33'd86 || v == 33'd118 ||
                  v == 33'd128) high_d = 1'b1;
            end
            7'd7: nxt = high_q ? 7'd8 : 7'd17;
            7'd8: begin
              if (v == 33'd3) f444_d = 1'b1;
              nxt = (v == 33'd3) ? 7'd9 : 7'd10;
            end
            7'd13: begin
              sln_d = 4'd0;
              nxt = flag_v ? h264sps_pkg::POS_LIST_FLAG : 7'd17;
            end
            h264sps_pkg::POS_LIST_FLAG: begin
              if (flag_v) begin
                cnt_d = 8'd0; prev_d = 8'd8; nxt = h264sps_pkg::POS_SCALE;
              end else begin
                sln_d = sln_inc[3:0]; nxt = ld_nxt;
              end
            end
            7'd18: nxt = (v == 33'd0) ? 7'd19 : ((v == 33'd1) ? 7'd20 : 7'd25);
            7'd19: nxt = 7'd25;
            7'd23: begin
              lim_d = (v > 33'd255) ? 8'd255 : v[7:0];
              cnt_d = 8'd0;
              nxt = (v != 33'd0) ? 7'd24 : 7'd25;
            end
            7'd24: begin
              cnt_d = cnt_inc[7:0];
              nxt = (cnt_inc < {1'b0, lim_q}) ? 7'd24 : 7'd25;
            end
            7'd29: nxt = flag_v ? 7'd31 : 7'd30;
            7'd32: nxt = flag_v ? 7'd33 : 7'd37;
            7'd37: nxt = flag_v ? 7'd38 : h264sps_pkg::POS_DONE;
            7'd38: nxt = flag_v ? 7'd39 : 7'd42;
            7'd39: nxt = (v == 33'd255) ? 7'd40 : 7'd42;
            7'd42: nxt = flag_v ? 7'd43 : 7'd44;
            7'd44: nxt = flag_v ? 7'd45 : 7'd51;
            7'd47: nxt = flag_v ? 7'd48 : 7'd51;
            7'd51: nxt = flag_v ? 7'd52 : 7'd54;
            7'd54: nxt = flag_v ? 7'd55 : 7'd58;
            7'd58: begin
              if (flag_v) nal_d = 1'b1;
              nxt = flag_v ? 7'd59 : 7'd69;
            end
            7'd59, 7'd70: begin
              lim_d = ((v > 33'd31) ? 8'd31 : v[7:0]) + 8'd1;
              cnt_d = 8'd0;
            end
            7'd64, 7'd75: begin
              cnt_d = cnt_inc[7:0];
              nxt = (cnt_inc < {1'b0, lim_q}) ? (pos_q - 7'd2) : (pos_q + 7'd1);
            end
            7'd68: nxt = 7'd69;
            7'd69: begin
              if (flag_v) vcl_d = 1'b1;
              nxt = flag_v ? 7'd70 : (nal_q ? 7'd80 : 7'd81);
            end
            7'd79: nxt = (nal_q || vcl_q) ? 7'd80 : 7'd81;
            7'd82: nxt = flag_v ? 7'd83 : h264sps_pkg::POS_DONE;
            7'd89: nxt = h264sps_pkg::POS_DONE;
            default: ;
          endcase
        end
        // Enter the next element
        nkind  = h264sps_pkg::kind_of(nxt);
        pos_d  = nxt;
        acc_d  = 32'd0;
        lz_d   = 6'd0;
        sfx_d  = 1'b0;
        left_d = ((nkind != 7'd0) && (nkind <= 7'd32)) ? nkind[5:0] : 6'd0;
      end
    end
  end

  // Control and decoder registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= h264sps_pkg::PH_IDLE;
      bit_q   <= 3'd0;
      oval_q  <= 1'b0;
      pos_q <= 7'd0; lz_q <= 6'd0; acc_q <= 32'd0; left_q <= 6'd8;
      cnt_q <= 8'd0; lim_q <= 8'd0; sln_q <= 4'd0; prev_q <= 8'd8;
      high_q <= 1'b0; f444_q <= 1'b0; nal_q <= 1'b0; vcl_q <= 1'b0; sfx_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (q_pop_o)   bit_q <= 3'd0;
      else if (step) bit_q <= bit_q + 3'd1;
      if (step) begin
        pos_q <= pos_d; lz_q <= lz_d; acc_q <= acc_d; left_q <= left_d;
        cnt_q <= cnt_d; lim_q <= lim_d; sln_q <= sln_d; prev_q <= prev_d;
        high_q <= high_d; f444_q <= f444_d; nal_q <= nal_d; vcl_q <= vcl_d;
        sfx_q <= sfx_d;
      end
      if (step && emit)  oval_q <= 1'b1;
      else if (m_ready_i) oval_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      byte_q <= q_entry_i.data;
      fin_q  <= q_entry_i.fin;
      drop_q <= q_entry_i.drop;
    end
    if (step && emit) ores_q <= eres;
  end

  assign m_valid_o = oval_q;
  assign m_res_o   = ores_q;

endmodule

FILE: rtl/h264sps_checker.sv
// Port-level checker for the SPS parser unit, bound to the top level.
// Depends on h264_sps_syntax_parser_unit_macros.svh.
`include "h264_sps_syntax_parser_unit_macros.svh"

module h264sps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // A stalled result holds
  `SPS_ASSERT_NXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // Marker element carries id 90, index 0 and value 0
  `SPS_ASSERT_IMP(a_marker, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, m_axis_tdata[6:0] == 7'd90 && m_axis_tdata[49:7] == 43'd0)

  // Early-end status only appears on the marker
  `SPS_ASSERT_IMP(a_early, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[51:50] != 2'd2)

  // Long-codeword element reports value 0
  `SPS_ASSERT_IMP(a_long, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[51:50] == 2'd1, m_axis_tdata[49:17] == 33'd0)

endmodule

bind h264_sps_syntax_parser_unit h264sps_checker u_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata),
  .m_axis_tlast(m_axis_tlast)
);

FILE: dv/h264_sps_syntax_parser_unit_checker.sv
// Checker for the SPS parser unit: predicts decoded syntax elements from the
// accepted payload bytes and compares them with the result stream.
// Depends on h264sps_pkg for the syntax kind table and status codes.
module h264_sps_syntax_parser_unit_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int         CODE_LIMIT = 32;
  localparam logic [7:0] FL_HIGH    = 8'h01;
  localparam logic [7:0] FL_444     = 8'h02;
  localparam logic [7:0] FL_NAL     = 8'h04;
  localparam logic [7:0] FL_VCL     = 8'h08;
  localparam logic [7:0] FL_SUFFIX  = 8'h10;
  localparam logic [7:0] P_DONE     = 8'(h264sps_pkg::POS_DONE);
  localparam logic [7:0] P_ERROR    = 8'(h264sps_pkg::POS_ERROR);

  typedef struct {
    logic [6:0]           id;
    logic [9:0]           index;
    logic [32:0]          value;
    h264sps_pkg::status_e status;
    logic                 eos;
  } element_t;

  element_t element_q[$];

  // Decoder state mirror
  logic [1:0]  zero_run;
  logic [7:0]  pos, lead_zeros, bits_left, loop_cnt, loop_lim, list_num;
  logic [7:0]  scale_prev, flags;
  logic [31:0] accum;
  int          mismatches;

  assign fail_count_o = mismatches;
  assign pending_o    = element_q.size();

  function automatic logic [6:0] kind_at(input logic [7:0] p);
    return (p < P_DONE) ? h264sps_pkg::KIND_TABLE[p] : 7'd0;
  endfunction

  function automatic bit is_fixed(input logic [7:0] p);
    return kind_at(p) >= 7'd1 && kind_at(p) <= 7'd32;
  endfunction

  function automatic void push_element(input logic [7:0] id, input logic [9:0] idx,
                                       input logic [63:0] val,
                                       input h264sps_pkg::status_e st,
                                       input logic eos);
    element_t e;
    e.id = id[6:0]; e.index = idx; e.value = val[32:0]; e.status = st; e.eos = eos;
    element_q.push_back(e);
  endfunction

  function automatic void goto_pos(input logic [7:0] p);
    pos = p; accum = '0; lead_zeros = '0; bits_left = '0;
    flags &= ~FL_SUFFIX;
    if (is_fixed(p)) bits_left = 8'(kind_at(p));
  endfunction

  function automatic void reset_decoder();
    zero_run = '0; loop_cnt = '0; loop_lim = '0; list_num = '0;
    scale_prev = 8'd8; flags = '0;
    goto_pos(8'd0);
  endfunction

  function automatic logic [9:0] index_at(input logic [7:0] p);
    case (p)
      8'd14: return 10'(list_num);
      8'd15: return 10'(list_num) * 10'd64 + 10'(loop_cnt);
      8'd24, 8'd62, 8'd63, 8'd64, 8'd73, 8'd74, 8'd75: return 10'(loop_cnt);
      default: return '0;
    endcase
  endfunction

  function automatic logic [7:0] next_list();
    list_num++;
    return (list_num < ((flags & FL_444) ? 8'd12 : 8'd8)) ? 8'd14 : 8'd17;
  endfunction

  function automatic logic [7:0] hrd_exit();
    return (flags & (FL_NAL | FL_VCL)) ? 8'd80 : 8'd81;
  endfunction

  // Syntax order and branch decisions
  function automatic logic [7:0] next_pos(input logic [7:0] p, input logic [63:0] v);
    case (p)
      8'd0: begin
        if (v inside {100, 110, 122, 244, 44, 83, 86, 118, 128}) flags |= FL_HIGH;
        return 8'd1;
      end
      8'd7:  return (flags & FL_HIGH) ? 8'd8 : 8'd17;
      8'd8: begin
        if (v == 3) begin
          flags |= FL_444;
          return 8'd9;
        end
        return 8'd10;
      end
      8'd13: begin
        list_num = '0;
        return v ? 8'd14 : 8'd17;
      end
      8'd14: begin
        if (v) begin
          loop_cnt = '0; scale_prev = 8'd8;
          return 8'd15;
        end
        return next_list();
      end
      8'd18: return v == 0 ? 8'd19 : (v == 1 ? 8'd20 : 8'd25);
      8'd19: return 8'd25;
      8'd23: begin
        loop_lim = v > 255 ? 8'd255 : v[7:0];
        loop_cnt = '0;
        return loop_lim ? 8'd24 : 8'd25;
      end
      8'd24: begin
        loop_cnt++;
        return loop_cnt < loop_lim ? 8'd24 : 8'd25;
      end
      8'd29: return v ? 8'd31 : 8'd30;
      8'd32: return v ? 8'd33 : 8'd37;
      8'd37: return v ? 8'd38 : P_DONE;
      8'd38: return v ? 8'd39 : 8'd42;
      8'd39: return v == 255 ? 8'd40 : 8'd42;
      8'd42: return v ? 8'd43 : 8'd44;
      8'd44: return v ? 8'd45 : 8'd51;
      8'd47: return v ? 8'd48 : 8'd51;
      8'd51: return v ? 8'd52 : 8'd54;
      8'd54: return v ? 8'd55 : 8'd58;
      8'd58: begin
        if (v) begin
          flags |= FL_NAL;
          return 8'd59;
        end
        return 8'd69;
      end
      8'd59, 8'd70: begin
        loop_lim = (v > 31 ? 8'd31 : v[7:0]) + 8'd1;
        loop_cnt = '0;
        return p + 8'd1;
      end
      8'd64, 8'd75: begin
        loop_cnt++;
        return loop_cnt < loop_lim ? p - 8'd2 : p + 8'd1;
      end
      8'd68: return 8'd69;
      8'd69: begin
        if (v) begin
          flags |= FL_VCL;
          return 8'd70;
        end
        return hrd_exit();
      end
      8'd79: return hrd_exit();
      8'd82: return v ? 8'd83 : P_DONE;
      8'd89: return P_DONE;
      default: return p + 8'd1;
    endcase
  endfunction

  function automatic void finish_element(input logic [63:0] code);
    logic [63:0] v, mag;
    logic [7:0]  ns, nxt;
    logic [9:0]  idx;
    v = code;
    if (kind_at(pos) == h264sps_pkg::K_SE) begin
      mag = (code + 64'd1) >> 1;
      v = code[0] ? mag : -mag;
    end
    if (pos == 8'd15) begin
      // scale recursion; a zero next scale holds the last one for the rest
      idx = index_at(pos);
      ns = scale_prev + v[7:0];
      if (ns == 0) begin
        push_element(8'(h264sps_pkg::ID_HELD_SCALE), idx, 64'(scale_prev),
                     h264sps_pkg::ST_OK, 1'b0);
        nxt = next_list();
      end else begin
        scale_prev = ns;
        push_element(8'd15, idx, 64'(ns), h264sps_pkg::ST_OK, 1'b0);
        loop_cnt++;
        nxt = loop_cnt < (list_num < 6 ? 8'd16 : 8'd64) ? 8'd15 : next_list();
      end
    end else begin
      push_element(pos, index_at(pos), v, h264sps_pkg::ST_OK, 1'b0);
      nxt = next_pos(pos, v);
    end
    goto_pos(nxt);
  endfunction

  function automatic void decode_bit(input logic b);
    if (pos >= P_DONE) return;
    if (is_fixed(pos)) begin
      accum = {accum[30:0], b};
      bits_left--;
      if (bits_left == 0) finish_element(64'(accum));
      return;
    end
    // Exp-Golomb: prefix of zeros, then suffix bits
    if (!(flags & FL_SUFFIX)) begin
      if (!b) begin
        lead_zeros++;
        if (lead_zeros >= CODE_LIMIT) begin
          push_element(pos, index_at(pos), '0, h264sps_pkg::ST_LONG, 1'b0);
          pos = P_ERROR;
        end
      end else if (lead_zeros == 0) begin
        finish_element('0);
      end else begin
        flags |= FL_SUFFIX;
        bits_left = lead_zeros;
        accum = '0;
      end
      return;
    end
    accum = {accum[30:0], b};
    bits_left--;
    if (bits_left == 0)
      finish_element(((64'd1 << lead_zeros) - 64'd1) + 64'(accum));
  endfunction

  function automatic void decode_byte(input logic [7:0] data, input logic fin);
    bit                   drop;
    h264sps_pkg::status_e st;
    drop = 1'b0;
    if (zero_run >= 2 && data == 8'h03) begin
      drop = 1'b1;
      zero_run = '0;
    end else if (data == 0) begin
      if (zero_run < 2) zero_run++;
    end else begin
      zero_run = '0;
    end
    if (!drop)
      for (int i = 7; i >= 0; i--) decode_bit(data[i]);
    if (fin) begin
      st = pos == P_DONE ? h264sps_pkg::ST_OK :
           (pos == P_ERROR ? h264sps_pkg::ST_LONG : h264sps_pkg::ST_EARLY);
      push_element(8'(h264sps_pkg::POS_DONE), '0, '0, st, 1'b1);
      reset_decoder();
    end
  endfunction

  // Predict on input transactions, compare on output transactions
  always @(posedge clk_i or negedge rst_ni) begin
    element_t e;
    bit       bad;
    if (!rst_ni) begin
      element_q.delete();
      mismatches = 0;
      reset_decoder();
    end else begin
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (element_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected element transaction: tdata=%h tlast=%b",
                     m_axis_tdata, m_axis_tlast);
        end else begin
          e = element_q.pop_front();
          bad = m_axis_tdata[6:0] !== e.id || m_axis_tdata[16:7] !== e.index ||
                m_axis_tdata[49:17] !== e.value || m_axis_tdata[51:50] !== e.status ||
                m_axis_tdata[55:52] !== 4'd0 || m_axis_tlast !== e.eos;
          if (bad) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"element mismatch: exp id=%0d idx=%0d val=%h st=%0d last=%b, ",
                        "got id=%0d idx=%0d val=%h st=%0d pad=%h last=%b"},
                       e.id, e.index, e.value, e.status, e.eos,
                       m_axis_tdata[6:0], m_axis_tdata[16:7], m_axis_tdata[49:17],
                       m_axis_tdata[51:50], m_axis_tdata[55:52], m_axis_tlast);
          end
        end
      end
    end
  end

endmodule

FILE: dv/tb.sv
// Testbench top for the SPS parser unit: builds parameter sets as bit strings,
// escapes and streams them with random gaps and stalls, and gives the verdict.
// Depends on h264_sps_syntax_parser_unit and h264_sps_syntax_parser_unit_checker.
module tb;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int ITEM_GOAL   = 500;
  localparam int CALM_ITEMS  = 420;
  localparam int DRAIN_WAIT  = 100;
  localparam int HIGH_PROF [9] = '{100, 110, 122, 244, 44, 83, 86, 118, 128};

  typedef enum int {SET_CLEAN, SET_TRUNC, SET_DROP_END} set_end_e;

  logic        clk;
  logic        rst_n;
  logic        s_tvalid, s_tlast, s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid, m_tready, m_tlast;
  logic [55:0] m_tdata;
  int          fail_count, pending;
  int          cycle_cnt = 0;
  int          bytes_sent = 0;
  int          stall_left = 0;
  bit          idle_on = 1'b1;
  bit          sps_bits[$];

  h264_sps_syntax_parser_unit uut (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
    .s_axis_tdata(s_tdata), .s_axis_tlast(s_tlast),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready),
    .m_axis_tdata(m_tdata), .m_axis_tlast(m_tlast)
  );

  h264_sps_syntax_parser_unit_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
    .s_axis_tdata(s_tdata), .s_axis_tlast(s_tlast),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready),
    .m_axis_tdata(m_tdata), .m_axis_tlast(m_tlast),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result-side stalls in short bursts
  initial m_tready = 1'b0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(0, 2);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic void put_bits(input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) sps_bits.push_back(v[i]);
  endfunction

  function automatic void put_ue(input logic [31:0] v);
    logic [32:0] code;
    int          n;
    code = 33'(v) + 33'd1;
    n = 33;
    while (!code[n-1]) n--;
    for (int i = 1; i < n; i++) sps_bits.push_back(1'b0);
    for (int i = n - 1; i >= 0; i--) sps_bits.push_back(code[i]);
  endfunction

  function automatic void put_se(input int v);
    put_ue(v > 0 ? 32'(2 * v - 1) : 32'(-2 * v));
  endfunction

  function automatic bit coin();
    return 1'($urandom_range(0, 1));
  endfunction

  // Mostly short codes, now and then a full-range one
  function automatic logic [31:0] any_ue();
    logic [31:0] v;
    v = $urandom;
    if ($urandom_range(0, 15) == 0) return v == 32'hFFFF_FFFF ? 32'hFFFF_FFFE : v;
    return $urandom_range(0, 6);
  endfunction

  function automatic int any_se();
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? 2147483647 : -2147483647;
    return int'($urandom_range(0, 12)) - 6;
  endfunction

  // Delta scales; a zero next scale ends the list early (at the start: default matrix)
  function automatic void put_scaling_list(input int size, input bit use_default);
    int last_sc, delta, nxt;
    last_sc = 8;
    for (int j = 0; j < size; j++) begin
      if ((use_default && j == 0) || $urandom_range(0, 24) == 0)
        delta = last_sc <= 128 ? -last_sc : 256 - last_sc;
      else if ($urandom_range(0, 7) == 0)
        delta = int'($urandom_range(0, 255)) - 128;
      else
        delta = int'($urandom_range(0, 16)) - 8;
      put_se(delta);
      nxt = (last_sc + delta) & 255;
      if (nxt == 0) break;
      last_sc = nxt;
    end
  endfunction

  function automatic void put_hrd(input bit rich);
    int cpb;
    cpb = (rich || $urandom_range(0, 7) == 0) ? $urandom_range(32, 40) : $urandom_range(0, 3);
    put_ue(cpb);
    put_bits($urandom, 4);
    put_bits($urandom, 4);
    for (int i = 0; i < (cpb > 31 ? 32 : cpb + 1); i++) begin
      put_ue(any_ue());
      put_ue(any_ue());
      put_bits($urandom, 1);
    end
    for (int i = 0; i < 4; i++) put_bits($urandom, 5);
  endfunction

  function automatic void put_vui(input bit rich);
    bit f, nal, vcl;
    int idc;
    f = rich | coin();
    put_bits(32'(f), 1);
    if (f) begin
      idc = (rich || coin()) ? 255 : $urandom_range(0, 255);
      put_bits(idc, 8);
      if (idc == 255) begin
        put_bits($urandom, 16);
        put_bits($urandom, 16);
      end
    end
    f = rich | coin();
    put_bits(32'(f), 1);
    if (f) put_bits($urandom, 1);
    f = rich | coin();
    put_bits(32'(f), 1);
    if (f) begin
      put_bits($urandom, 3);
      put_bits($urandom, 1);
      f = rich | coin();
      put_bits(32'(f), 1);
      if (f) put_bits($urandom, 24);
    end
    f = rich | coin();
    put_bits(32'(f), 1);
    if (f) begin
      put_ue(any_ue());
      put_ue(any_ue());
    end
    f = rich | coin();
    put_bits(32'(f), 1);
    if (f) begin
      put_bits($urandom, 32);
      put_bits($urandom, 32);
      put_bits($urandom, 1);
    end
    nal = rich | coin();
    put_bits(32'(nal), 1);
    if (nal) put_hrd(rich);
    vcl = rich | coin();
    put_bits(32'(vcl), 1);
    if (vcl) put_hrd(rich);
    if (nal || vcl) put_bits($urandom, 1);
    put_bits($urandom, 1);
    f = rich | coin();
    put_bits(32'(f), 1);
    if (f) begin
      put_bits($urandom, 1);
      for (int i = 0; i < 6; i++) put_ue(any_ue());
    end
  endfunction

  // Well-formed SPS with random content; rich forces most optional parts on
  function automatic void build_sps(input bit rich);
    int  prof, chroma, poc, ncyc;
    bit  hi, f;
    prof = rich ? 244 : (coin() ? HIGH_PROF[$urandom_range(0, 8)] : $urandom_range(0, 255));
    hi = 1'b0;
    foreach (HIGH_PROF[i]) if (HIGH_PROF[i] == prof) hi = 1'b1;
    put_bits(prof, 8);
    put_bits($urandom, 8);
    put_bits($urandom, 8);
    put_ue($urandom_range(0, 31));
    if (hi) begin
      chroma = rich ? 3 : $urandom_range(0, 3);
      put_ue(chroma);
      if (chroma == 3) put_bits($urandom, 1);
      put_ue(any_ue());
      put_ue(any_ue());
      put_bits($urandom, 1);
      f = rich | coin();
      put_bits(32'(f), 1);
      if (f)
        for (int i = 0; i < (chroma == 3 ? 12 : 8); i++) begin
          f = rich | coin();
          put_bits(32'(f), 1);
          if (f) put_scaling_list(i < 6 ? 16 : 64, rich && i == 0);
        end
    end
    put_ue(any_ue());
    poc = rich ? 1 : ($urandom_range(0, 7) == 0 ? $urandom_range(3, 9) : $urandom_range(0, 2));
    put_ue(poc);
    if (poc == 0) begin
      put_ue(any_ue());
    end else if (poc == 1) begin
      put_bits($urandom, 1);
      put_se(any_se());
      put_se(any_se());
      ncyc = (rich || $urandom_range(0, 9) == 0) ? $urandom_range(256, 300)
                                                  : $urandom_range(0, 4);
      put_ue(ncyc);
      for (int i = 0; i < (ncyc > 255 ? 255 : ncyc); i++)
        put_se($urandom_range(0, 3) == 0 ? any_se() : 0);
    end
    put_ue(any_ue());
    put_bits($urandom, 1);
    put_ue(any_ue());
    put_ue(any_ue());
    f = coin();
    put_bits(32'(f), 1);
    if (!f) put_bits($urandom, 1);
    put_bits($urandom, 1);
    f = rich | coin();
    put_bits(32'(f), 1);
    if (f) for (int i = 0; i < 4; i++) put_ue(any_ue());
    f = rich | coin();
    put_bits(32'(f), 1);
    if (f) put_vui(rich);
  endfunction

  // One byte transaction, with an optional idle burst ahead of it
  task automatic send_byte(input logic [7:0] data, input logic fin);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    if (bytes_sent >= CALM_ITEMS) idle_on = 1'b0;
  endtask

  // Valid stays up after the last byte; the caller drops it before waiting
  task automatic send_queue(ref logic [7:0] q[$]);
    for (int i = 0; i < q.size(); i++) send_byte(q[i], i == q.size() - 1);
  endtask

  // Stop bit and padding, bytes, emulation prevention, then stream
  task automatic finish_set(input set_end_e how);
    logic [7:0] raw[$];
    logic [7:0] esc[$];
    logic [7:0] b;
    int         zr;
    sps_bits.push_back(1'b1);
    while (sps_bits.size() % 8 != 0) sps_bits.push_back(1'b0);
    for (int i = 0; i < sps_bits.size(); i += 8) begin
      for (int k = 0; k < 8; k++) b[7-k] = sps_bits[i+k];
      raw.push_back(b);
    end
    sps_bits.delete();
    zr = 0;
    foreach (raw[i]) begin
      if (zr >= 2 && raw[i] <= 8'h03) begin
        esc.push_back(8'h03);
        zr = 0;
      end
      esc.push_back(raw[i]);
      zr = raw[i] == 0 ? zr + 1 : 0;
    end
    if (how == SET_TRUNC && esc.size() > 1)
      esc = esc[0:$urandom_range(0, esc.size() - 2)];
    if (how == SET_DROP_END) begin
      esc.push_back(8'h00);
      esc.push_back(8'h00);
      esc.push_back(8'h03);
    end
    send_queue(esc);
  endtask

  // Codeword with too many leading zeros at the sps id
  task automatic long_code_set();
    put_bits($urandom, 24);
    put_bits(0, 32);
    put_bits($urandom, 8);
    finish_set(SET_CLEAN);
  endtask

  // Unstructured bytes, heavy on zeros and escapes
  task automatic noise_set();
    logic [7:0] q[$];
    repeat ($urandom_range(1, 12))
      case ($urandom_range(0, 5))
        0, 1:    q.push_back(8'h00);
        2:       q.push_back(8'h03);
        default: q.push_back(8'($urandom));
      endcase
    send_queue(q);
  endtask

  initial begin
    int pick;
    rst_n    = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, error endings, escapes, one set with most branches taken
    begin
      logic [7:0] q[$];
      q = '{8'hFF, 8'h00, 8'h00, 8'h03, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF};
      send_queue(q);
    end
    long_code_set();
    build_sps(1'b0);
    finish_set(SET_TRUNC);
    build_sps(1'b0);
    finish_set(SET_DROP_END);
    build_sps(1'b1);
    finish_set(SET_CLEAN);

    // Hold off until every element has come out
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    // Random sets, mostly well formed
    while (bytes_sent < ITEM_GOAL) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        build_sps(1'b0);
        finish_set(SET_CLEAN);
      end else if (pick < 16) begin
        build_sps(1'b0);
        finish_set(SET_TRUNC);
      end else if (pick < 17) begin
        build_sps(1'b0);
        finish_set(SET_DROP_END);
      end else if (pick < 18) begin
        long_code_set();
      end else begin
        noise_set();
      end
    end

    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
